// File: design/vcsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity command slew limiter package
// Shared types, codes and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package vcsl_pkg;

    // Gait mode codes carried by the cmd field.
    localparam logic [1:0] MODE_SLOW    = 2'd0;
    localparam logic [1:0] MODE_FAST    = 2'd1;
    localparam logic [1:0] MODE_OVERLAP = 2'd2;
    localparam logic [1:0] MODE_STOP    = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SLEW_STEP   = 3'd0;
    localparam logic [2:0] CFG_STOP_THRESH = 3'd1;
    localparam logic [2:0] CFG_LIM_SLOW    = 3'd2;
    localparam logic [2:0] CFG_LIM_FAST    = 3'd3;
    localparam logic [2:0] CFG_LIM_OVERLAP = 3'd4;
    localparam logic [2:0] CFG_YAW_LIMIT   = 3'd5;
    localparam logic [2:0] CFG_JOY_TIMEOUT = 3'd6;

    // Iteration counts of the shared square root and divider.
    localparam int          SQRT_STEPS = 17;
    localparam int          DIV_STEPS  = 14;
    localparam logic [4:0]  SQRT_LAST  = 5'(SQRT_STEPS - 1);
    localparam logic [4:0]  DIV_LAST   = 5'(DIV_STEPS - 1);
    localparam logic [1:0]  AXIS_LAST  = 2'd2;
    localparam logic [16:0] IDLE_MAX   = 17'h1FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_D,
        ST_SQ_ST,
        ST_CHECK,
        ST_SQRT,
        ST_DIV_MUL,
        ST_DIV,
        ST_DIV_END,
        ST_STOP_SQ,
        ST_STOP_TH,
        ST_WRITE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_D,
        OP_SQ_ST,
        OP_SNAP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_MUL,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_STOP_SQ,
        OP_STOP_TH,
        OP_WRITE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
    } t_dp_cmd;

    typedef struct packed {
        logic snap;
        logic step_zero;
    } t_dp_status;

endpackage

// File: design/vcsl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel interface
// One beat per control tick: mode, joystick sample and base speeds.
// ----------------------------------------------------------------------------
interface vcsl_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  cmd;
    logic               joy_fresh;
    logic signed [15:0] joy_vx;
    logic signed [15:0] joy_vy;
    logic signed [15:0] joy_vz;
    logic signed [15:0] joy_yaw_rate;
    logic        [15:0] base_speed;
    logic        [15:0] base_turn_speed;

    modport source(output valid, cmd, joy_fresh, joy_vx, joy_vy, joy_vz, joy_yaw_rate,
                   base_speed, base_turn_speed, input ready);
    modport sink(input valid, cmd, joy_fresh, joy_vx, joy_vy, joy_vz, joy_yaw_rate,
                 base_speed, base_turn_speed, output ready);
endinterface

// File: design/vcsl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output channel interface
// One beat per tick: limited velocity command and the stop flag.
// ----------------------------------------------------------------------------
interface vcsl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cmd_vx;
    logic signed [15:0] cmd_vy;
    logic signed [15:0] cmd_vz;
    logic signed [15:0] cmd_yaw_rate;
    logic               stop_reached;

    modport source(output valid, cmd_vx, cmd_vy, cmd_vz, cmd_yaw_rate, stop_reached,
                   input ready);
    modport sink(input valid, cmd_vx, cmd_vy, cmd_vz, cmd_yaw_rate, stop_reached,
                 output ready);
endinterface

// File: design/vcsl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slew limiter controller
// Sequences the datapath through squaring, square root, division and the
// stop test, and owns the input ready and output valid handshakes.
// ----------------------------------------------------------------------------
module vcsl_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  vcsl_pkg::t_dp_status  i_status,
    output vcsl_pkg::t_dp_cmd     o_cmd
);
    import vcsl_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_axis, n_axis;
    logic       r_out_valid, n_out_valid;

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_axis      = r_axis;
        n_out_valid = r_out_valid;
        o_cmd.op    = OP_NONE;
        o_cmd.axis  = r_axis;
        o_in_ready  = 1'b0;

        // A waiting beat leaves when the sink takes it.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_axis   = '0;
                    n_state  = ST_SQ_D;
                end
            end
            ST_SQ_D: begin
                o_cmd.op = OP_SQ_D;
                if (r_axis == AXIS_LAST) begin
                    n_axis  = '0;
                    n_state = ST_SQ_ST;
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            ST_SQ_ST: begin
                o_cmd.op = OP_SQ_ST;
                n_state  = ST_CHECK;
            end
            ST_CHECK: begin
                n_axis = '0;
                n_cnt  = '0;
                if (i_status.step_zero) begin
                    n_state = ST_STOP_SQ;
                end else if (i_status.snap) begin
                    o_cmd.op = OP_SNAP;
                    n_state  = ST_STOP_SQ;
                end else begin
                    o_cmd.op = OP_SQRT_INIT;
                    n_state  = ST_SQRT;
                end
            end
            ST_SQRT: begin
                o_cmd.op = OP_SQRT_STEP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == SQRT_LAST) begin
                    n_state = ST_DIV_MUL;
                end
            end
            ST_DIV_MUL: begin
                o_cmd.op = OP_DIV_MUL;
                n_cnt    = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                o_cmd.op = OP_DIV_END;
                if (r_axis == AXIS_LAST) begin
                    n_axis  = '0;
                    n_state = ST_STOP_SQ;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = ST_DIV_MUL;
                end
            end
            ST_STOP_SQ: begin
                o_cmd.op = OP_STOP_SQ;
                if (r_axis == AXIS_LAST) begin
                    n_axis  = '0;
                    n_state = ST_STOP_TH;
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            ST_STOP_TH: begin
                o_cmd.op = OP_STOP_TH;
                n_state  = ST_WRITE;
            end
            ST_WRITE: begin
                // The output register frees up in this cycle or is already empty.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_WRITE;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: design/vcsl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slew limiter datapath
// Configuration registers, kept command state, one shared multiplier, a
// bit-serial integer square root and a restoring divider, plus output registers.
// ----------------------------------------------------------------------------
module vcsl_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    input  logic [1:0]            i_cmd,
    input  logic                  i_joy_fresh,
    input  logic signed [15:0]    i_joy_vx,
    input  logic signed [15:0]    i_joy_vy,
    input  logic signed [15:0]    i_joy_vz,
    input  logic signed [15:0]    i_joy_yaw_rate,
    input  logic [15:0]           i_base_speed,
    input  logic [15:0]           i_base_turn_speed,
    input  vcsl_pkg::t_dp_cmd     i_ctl,
    output vcsl_pkg::t_dp_status  o_status,
    output logic signed [15:0]    o_cmd_vx,
    output logic signed [15:0]    o_cmd_vy,
    output logic signed [15:0]    o_cmd_vz,
    output logic signed [15:0]    o_cmd_yaw_rate,
    output logic                  o_stop_reached
);
    import vcsl_pkg::*;

    // Configuration.
    logic [12:0] r_slew_step;
    logic [14:0] r_stop_th, r_lim_slow, r_lim_fast, r_lim_overlap, r_yaw_lim;
    logic [15:0] r_joy_timeout;

    // Kept state and per-tick operands.
    logic signed [15:0] r_cmd [3];
    logic signed [15:0] r_tgt [3];
    logic signed [15:0] r_yaw;
    logic [16:0]        r_idle;
    logic [1:0]         r_mode;
    logic [15:0]        r_base, r_turn;

    // Arithmetic registers.
    logic [33:0] r_acc;
    logic [29:0] r_aux;
    logic [33:0] r_sq_src;
    logic [18:0] r_sq_rem;
    logic [16:0] r_root;
    logic [13:0] r_num_lo;
    logic [17:0] r_div_rem;
    logic [13:0] r_quot;

    // Output registers.
    logic signed [15:0] r_out_cmd [3];
    logic signed [15:0] r_out_yaw;
    logic               r_out_stop;

    logic signed [16:0] d_sel;
    logic [15:0]        mag_sel;
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] prod;
    logic               use_joy;
    logic [14:0]        lin_lim;
    logic [30:0]        div_num;
    logic [17:0]        div_den;
    logic [20:0]        sq_t, sq_trial;
    logic [18:0]        dv_t;
    logic signed [17:0] upd_sum;
    logic signed [15:0] joy_src [3];

    // Symmetric clamp of a signed sample to a magnitude limit.
    function automatic logic signed [15:0] clamp_sym(logic signed [15:0] v,
                                                     logic [14:0] lim);
        logic signed [16:0] vs, ls;
        vs = 17'(v);
        ls = signed'({2'b00, lim});
        if (vs > ls)       clamp_sym = 16'(ls);
        else if (vs < -ls) clamp_sym = 16'(-ls);
        else               clamp_sym = v;
    endfunction

    assign joy_src[0] = i_joy_vx;
    assign joy_src[1] = i_joy_vy;
    assign joy_src[2] = i_joy_vz;

    // Target selection terms for a new beat.
    always_comb begin
        use_joy = i_joy_fresh || (r_idle <= {1'b0, r_joy_timeout});
        unique case (i_cmd)
            MODE_SLOW: lin_lim = r_lim_slow;
            MODE_FAST: lin_lim = r_lim_fast;
            default:   lin_lim = r_lim_overlap;
        endcase
    end

    // Difference of the selected axis and its magnitude.
    always_comb begin
        d_sel   = 17'(r_tgt[i_ctl.axis]) - 17'(r_cmd[i_ctl.axis]);
        mag_sel = d_sel[16] ? 16'(-d_sel) : d_sel[15:0];
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_ctl.op)
            OP_SQ_D: begin
                mul_a = 18'(d_sel);
                mul_b = 18'(d_sel);
            end
            OP_SQ_ST: begin
                mul_a = signed'({5'b0, r_slew_step});
                mul_b = signed'({5'b0, r_slew_step});
            end
            OP_DIV_MUL: begin
                mul_a = signed'({5'b0, r_slew_step});
                mul_b = signed'({2'b0, mag_sel});
            end
            OP_STOP_SQ: begin
                mul_a = 18'(r_cmd[i_ctl.axis]);
                mul_b = 18'(r_cmd[i_ctl.axis]);
            end
            OP_STOP_TH: begin
                mul_a = signed'({3'b0, r_stop_th});
                mul_b = signed'({3'b0, r_stop_th});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // Square root digit, divider numerator and quotient digit.
    always_comb begin
        sq_t     = {r_sq_rem[18:0], r_sq_src[33:32]};
        sq_trial = {2'b00, r_root, 2'b01};
        div_num  = {prod[29:0], 1'b0} + {14'b0, r_root};
        div_den  = {r_root, 1'b0};
        dv_t     = {r_div_rem, r_num_lo[13]};
        upd_sum  = d_sel[16] ? 18'(r_cmd[i_ctl.axis]) - 18'({1'b0, r_quot})
                             : 18'(r_cmd[i_ctl.axis]) + 18'({1'b0, r_quot});
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slew_step   <= 13'd4;
            r_stop_th     <= 15'd410;
            r_lim_slow    <= 15'd2867;
            r_lim_fast    <= 15'd4915;
            r_lim_overlap <= 15'd4096;
            r_yaw_lim     <= 15'd2867;
            r_joy_timeout <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SLEW_STEP:   r_slew_step   <= i_cfg_data[12:0];
                CFG_STOP_THRESH: r_stop_th     <= i_cfg_data[14:0];
                CFG_LIM_SLOW:    r_lim_slow    <= i_cfg_data[14:0];
                CFG_LIM_FAST:    r_lim_fast    <= i_cfg_data[14:0];
                CFG_LIM_OVERLAP: r_lim_overlap <= i_cfg_data[14:0];
                CFG_YAW_LIMIT:   r_yaw_lim     <= i_cfg_data[14:0];
                CFG_JOY_TIMEOUT: r_joy_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Kept command state and timeout counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd[0] <= '0;
            r_cmd[1] <= '0;
            r_cmd[2] <= '0;
            r_yaw    <= '0;
            r_idle   <= '0;
        end else begin
            unique case (i_ctl.op)
                OP_LOAD: begin
                    if (i_joy_fresh)           r_idle <= '0;
                    else if (r_idle != IDLE_MAX) r_idle <= r_idle + 17'd1;
                    if (i_cmd != MODE_STOP) begin
                        r_yaw <= clamp_sym(use_joy ? i_joy_yaw_rate : 16'sd0, r_yaw_lim);
                    end
                end
                OP_SNAP: begin
                    r_cmd[0] <= r_tgt[0];
                    r_cmd[1] <= r_tgt[1];
                    r_cmd[2] <= r_tgt[2];
                end
                OP_DIV_END: begin
                    if (upd_sum > 18'sd32767)       r_cmd[i_ctl.axis] <= 16'sh7FFF;
                    else if (upd_sum < -18'sd32768) r_cmd[i_ctl.axis] <= 16'sh8000;
                    else                            r_cmd[i_ctl.axis] <= upd_sum[15:0];
                end
                default: ;
            endcase
        end
    end

    // Per-tick operands and the iterative arithmetic.
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_LOAD: begin
                for (int k = 0; k < 3; k++) begin
                    if (i_cmd == MODE_STOP || !use_joy) r_tgt[k] <= '0;
                    else                                r_tgt[k] <= clamp_sym(joy_src[k], lin_lim);
                end
                r_mode <= i_cmd;
                r_base <= i_base_speed;
                r_turn <= i_base_turn_speed;
            end
            OP_SQ_D, OP_STOP_SQ: begin
                if (i_ctl.axis == '0) r_acc <= prod[33:0];
                else                  r_acc <= r_acc + prod[33:0];
            end
            OP_SQ_ST, OP_STOP_TH: begin
                r_aux <= prod[29:0];
            end
            OP_SQRT_INIT: begin
                r_sq_src <= r_acc;
                r_sq_rem <= '0;
                r_root   <= '0;
            end
            OP_SQRT_STEP: begin
                r_sq_src <= {r_sq_src[31:0], 2'b00};
                if (sq_t >= sq_trial) begin
                    r_sq_rem <= 19'(sq_t - sq_trial);
                    r_root   <= {r_root[15:0], 1'b1};
                end else begin
                    r_sq_rem <= sq_t[18:0];
                    r_root   <= {r_root[15:0], 1'b0};
                end
            end
            OP_DIV_MUL: begin
                r_div_rem <= {1'b0, div_num[30:14]};
                r_num_lo  <= div_num[13:0];
                r_quot    <= '0;
            end
            OP_DIV_STEP: begin
                r_num_lo <= {r_num_lo[12:0], 1'b0};
                if (dv_t >= {1'b0, div_den}) begin
                    r_div_rem <= 18'(dv_t - {1'b0, div_den});
                    r_quot    <= {r_quot[12:0], 1'b1};
                end else begin
                    r_div_rem <= dv_t[17:0];
                    r_quot    <= {r_quot[12:0], 1'b0};
                end
            end
            OP_WRITE: begin
                r_out_cmd[0] <= r_cmd[0];
                r_out_cmd[1] <= r_cmd[1];
                r_out_cmd[2] <= r_cmd[2];
                r_out_yaw    <= r_yaw;
                r_out_stop   <= (r_mode == MODE_STOP) && (r_acc <= {4'b0, r_aux})
                                && (r_base <= {1'b0, r_stop_th})
                                && (r_turn <= {1'b0, r_stop_th});
            end
            default: ;
        endcase
    end

    assign o_status.snap      = r_acc < {4'b0, r_aux};
    assign o_status.step_zero = (r_slew_step == '0);

    assign o_cmd_vx       = r_out_cmd[0];
    assign o_cmd_vy       = r_out_cmd[1];
    assign o_cmd_vz       = r_out_cmd[2];
    assign o_cmd_yaw_rate = r_out_yaw;
    assign o_stop_reached = r_out_stop;

endmodule

// File: design/velocity_command_slew_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity command slew limiter
// Moves a kept 3D velocity command toward a clamped joystick target by a
// fixed step per tick, passes a clamped yaw rate and flags a reached stop.
//
// Usage:
//   i_in carries one beat per control tick; o_out returns exactly one beat
//   for each. Registers are written on i_cfg_we/i_cfg_idx/i_cfg_data; the
//   user must write them while the block is idle; this is not enforced.
//   After the input accept the controller squares the three axis differences
//   on the shared multiplier, then squares the step and makes the snap check.
//   When the command snaps to its target or the step is zero it goes on to
//   the stop test; when it slews it first runs 17 square root steps and three
//   divisions, one per axis. The stop test and the write close the tick.
//   A new beat is accepted the cycle after the result is written, so a new
//   beat is taken only once the previous result has been written.
//   The result sits in an output register; a stalled receiver does not block
//   the next accept, only the following write-out waits for the register.
//   Synchronous reset clears the command state, the timeout counter and the
//   output valid, and restores register defaults.
// ----------------------------------------------------------------------------
module velocity_command_slew_limiter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    vcsl_in_if.sink     i_in,
    vcsl_out_if.source  o_out
);
    import vcsl_pkg::*;

    t_dp_cmd    ctl;
    t_dp_status status;

    vcsl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (ctl)
    );

    vcsl_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (i_in.cmd),
        .i_joy_fresh       (i_in.joy_fresh),
        .i_joy_vx          (i_in.joy_vx),
        .i_joy_vy          (i_in.joy_vy),
        .i_joy_vz          (i_in.joy_vz),
        .i_joy_yaw_rate    (i_in.joy_yaw_rate),
        .i_base_speed      (i_in.base_speed),
        .i_base_turn_speed (i_in.base_turn_speed),
        .i_ctl             (ctl),
        .o_status          (status),
        .o_cmd_vx          (o_out.cmd_vx),
        .o_cmd_vy          (o_out.cmd_vy),
        .o_cmd_vz          (o_out.cmd_vz),
        .o_cmd_yaw_rate    (o_out.cmd_yaw_rate),
        .o_stop_reached    (o_out.stop_reached)
    );

endmodule

// File: design/vcsl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slew limiter port checker
// Watches the top-level channels for ordering and handshake slips.
// ----------------------------------------------------------------------------
module vcsl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_cmd_vx,
    input logic [15:0] i_cmd_yaw_rate,
    input logic        i_stop_reached
);

    // A stalled output beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cmd_vx)
            && $stable(i_cmd_yaw_rate) && $stable(i_stop_reached))
        else $error("output beat changed while stalled");

    // One tick is worked at a time: accept closes the input side.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while a tick is in flight");

    // A new result appears only at the end of a tick, never in idle.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result written while idle");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind velocity_command_slew_limiter vcsl_checker u_vcsl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_cmd_vx       (o_out.cmd_vx),
    .i_cmd_yaw_rate (o_out.cmd_yaw_rate),
    .i_stop_reached (o_out.stop_reached)
);

// File: test/velocity_command_slew_limiter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity command slew limiter testbench
// Drives control ticks with random gaps and output stalls, predicts each
// result from a behavioral model of the slew limiter kept in this file, and
// compares every output beat field by field. Register settings change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module velocity_command_slew_limiter_tb;
    import vcsl_pkg::*;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               fresh;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic signed [15:0] yaw;
        logic [15:0]        base;
        logic [15:0]        turn;
    } t_tick;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic signed [15:0] yaw;
        logic               stop;
    } t_cmd_out;

    // Directed row: a tick, an optional typed-in expectation.
    typedef struct packed {
        t_tick    tick;
        logic     has_exp;
        t_cmd_out exp_out;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    vcsl_in_if  in_ch();
    vcsl_out_if out_ch();

    velocity_command_slew_limiter dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of registers and state.
    longint step_r, thresh_r, lim_slow_r, lim_fast_r, lim_ovl_r, yaw_lim_r, tmo_r;
    longint lin_cmd[3];
    longint yaw_cmd;
    longint idle_cnt;

    t_cmd_out pending_cmds[$];
    int       mismatches = 0;
    bit       stim_done = 1'b0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.cmd = '0;
        in_ch.joy_fresh = 1'b0;
        in_ch.joy_vx = '0;
        in_ch.joy_vy = '0;
        in_ch.joy_vz = '0;
        in_ch.joy_yaw_rate = '0;
        in_ch.base_speed = '0;
        in_ch.base_turn_speed = '0;
        out_ch.ready = 1'b0;
    end

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Bitwise floor square root; the squared norm stays below 2^35.
    function automatic longint floor_sqrt(longint v);
        longint r;
        r = 0;
        for (longint b = 64'h1 << 20; b > 0; b = b >> 1)
            if ((r + b) * (r + b) <= v) r = r + b;
        return r;
    endfunction

    function automatic void reset_model();
        step_r = 4; thresh_r = 410; lim_slow_r = 2867; lim_fast_r = 4915;
        lim_ovl_r = 4096; yaw_lim_r = 2867; tmo_r = 1000;
        lin_cmd[0] = 0; lin_cmd[1] = 0; lin_cmd[2] = 0;
        yaw_cmd = 0; idle_cnt = 0;
    endfunction

    function automatic void model_write_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            CFG_SLEW_STEP: begin
                step_r = val[12:0];
            end
            CFG_STOP_THRESH: begin
                thresh_r = val[14:0];
            end
            CFG_LIM_SLOW: begin
                lim_slow_r = val[14:0];
            end
            CFG_LIM_FAST: begin
                lim_fast_r = val[14:0];
            end
            CFG_LIM_OVERLAP: begin
                lim_ovl_r = val[14:0];
            end
            CFG_YAW_LIMIT: begin
                yaw_lim_r = val[14:0];
            end
            CFG_JOY_TIMEOUT: begin
                tmo_r = val;
            end
            default: begin
            end
        endcase
    endfunction

    // Advance the slew limiter by one tick and return the command it gives.
    function automatic t_cmd_out slew_tick(t_tick t);
        longint   tgt[3];
        longint   d[3];
        longint   tyaw, s, n, mag, q, lim, c;
        bit       use_joy;
        t_cmd_out r;
        tgt[0] = t.vx; tgt[1] = t.vy; tgt[2] = t.vz; tyaw = t.yaw;
        if (t.fresh) begin
            use_joy = 1'b1;
            idle_cnt = 0;
        end else begin
            use_joy = idle_cnt <= tmo_r;
            if (idle_cnt < 131071) idle_cnt++;
        end
        if (!use_joy) begin
            tgt[0] = 0; tgt[1] = 0; tgt[2] = 0; tyaw = 0;
        end
        if (t.cmd == MODE_STOP) begin
            tgt[0] = 0; tgt[1] = 0; tgt[2] = 0;
        end else begin
            lim = (t.cmd == MODE_SLOW) ? lim_slow_r :
                  (t.cmd == MODE_FAST) ? lim_fast_r : lim_ovl_r;
            for (int i = 0; i < 3; i++) tgt[i] = clamp_sym(tgt[i], lim);
            yaw_cmd = clamp_sym(tyaw, yaw_lim_r);
        end
        s = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = tgt[i] - lin_cmd[i];
            s += d[i] * d[i];
        end
        if (step_r != 0) begin
            if (s < step_r * step_r) begin
                for (int i = 0; i < 3; i++) lin_cmd[i] = tgt[i];
            end else begin
                n = floor_sqrt(s);
                for (int i = 0; i < 3; i++) begin
                    mag = d[i] < 0 ? -d[i] : d[i];
                    q = (2 * step_r * mag + n) / (2 * n);
                    lin_cmd[i] = sat16(lin_cmd[i] + (d[i] < 0 ? -q : q));
                end
            end
        end
        r.stop = 1'b0;
        if (t.cmd == MODE_STOP) begin
            c = lin_cmd[0] * lin_cmd[0] + lin_cmd[1] * lin_cmd[1] + lin_cmd[2] * lin_cmd[2];
            r.stop = (c <= thresh_r * thresh_r) && (t.base <= thresh_r) &&
                     (t.turn <= thresh_r);
        end
        r.vx = 16'(lin_cmd[0]); r.vy = 16'(lin_cmd[1]); r.vz = 16'(lin_cmd[2]);
        r.yaw = 16'(yaw_cmd);
        return r;
    endfunction

    function automatic t_tick make_tick(logic [1:0] m, logic f, int x, int y, int z,
                                        int w, int b, int tr);
        t_tick t;
        t.cmd = m; t.fresh = f; t.vx = 16'(x); t.vy = 16'(y); t.vz = 16'(z);
        t.yaw = 16'(w); t.base = 16'(b); t.turn = 16'(tr);
        return t;
    endfunction

    // Random tick: mostly fresh commands near the limits, some noise.
    function automatic t_tick rand_tick();
        t_tick t;
        int    k;
        t = t_tick'({$urandom, $urandom, $urandom, $urandom});
        k = $urandom_range(0, 9);
        if (k < 6) begin
            t.vx = $signed(16'($urandom_range(0, 12000))) - 16'sd6000;
            t.vy = $signed(16'($urandom_range(0, 12000))) - 16'sd6000;
            t.vz = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            t.fresh = ($urandom_range(0, 7) != 0);
            t.base = 16'($urandom_range(0, 800));
            t.turn = 16'($urandom_range(0, 800));
        end
        return t;
    endfunction

    // One register write, then the write port is left quiet before the task returns.
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Hold the input idle and wait until every predicted command has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Send one beat after a random gap; an expectation is queued on accept.
    task automatic send_tick(t_tick t, bit has_exp, t_cmd_out typed);
        t_cmd_out p;
        int       gap;
        gap = $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= t.cmd;
        in_ch.joy_fresh <= t.fresh;
        in_ch.joy_vx <= t.vx;
        in_ch.joy_vy <= t.vy;
        in_ch.joy_vz <= t.vz;
        in_ch.joy_yaw_rate <= t.yaw;
        in_ch.base_speed <= t.base;
        in_ch.base_turn_speed <= t.turn;
        do @(posedge i_clk); while (!in_ch.ready);
        p = slew_tick(t);
        if (has_exp && p != typed) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with predictor: row %h pred %h", typed, p);
        end
        pending_cmds.push_back(p);
    endtask

    // Result checker with random stalls on the receive side.
    initial begin
        t_cmd_out e;
        t_cmd_out got;
        int       hold;
        @(posedge i_clk);
        forever begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (hold != 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got = {out_ch.cmd_vx, out_ch.cmd_vy, out_ch.cmd_vz, out_ch.cmd_yaw_rate,
                   out_ch.stop_reached};
            if (pending_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected command beat %h", got);
            end else begin
                e = pending_cmds.pop_front();
                if (got !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("command mismatch: exp vx %0d vy %0d vz %0d yaw %0d stop %0b,",
                                 e.vx, e.vy, e.vz, e.yaw, e.stop,
                                 " got vx %0d vy %0d vz %0d yaw %0d stop %0b",
                                 got.vx, got.vy, got.vz, got.yaw, got.stop);
                end
            end
        end
    end

    // Main stimulus.
    initial begin
        t_row  rows[$];
        t_row  r;
        t_tick t;
        reset_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; typed-in values only for the obvious rows.
        r = '0; r.tick = make_tick(MODE_STOP, 1, 0, 0, 0, 0, 0, 0);
        r.has_exp = 1; r.exp_out = {16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}; rows.push_back(r);
        r = '0; r.tick = make_tick(MODE_STOP, 1, 0, 0, 0, 0, 411, 0);
        r.has_exp = 1; r.exp_out = '0; rows.push_back(r);
        r = '0; r.tick = make_tick(MODE_SLOW, 1, 3, 0, 0, 32767, 0, 0);
        r.has_exp = 1; r.exp_out = {16'sd3, 16'sd0, 16'sd0, 16'sd2867, 1'b0}; rows.push_back(r);
        r = '0; r.tick = make_tick(MODE_FAST, 1, 32767, -32768, 32767, -32768, 0, 0);
        rows.push_back(r);
        r = '0; r.tick = make_tick(MODE_OVERLAP, 1, -32768, 32767, -32768, 100, 65535, 65535);
        rows.push_back(r);
        r = '0; r.tick = make_tick(MODE_STOP, 0, 1, 1, 1, 1, 65535, 0);
        rows.push_back(r);
        r = '0; r.tick = make_tick(MODE_SLOW, 0, 1000, 1000, 1000, 1000, 0, 65535);
        rows.push_back(r);
        foreach (rows[i]) send_tick(rows[i].tick, rows[i].has_exp, rows[i].exp_out);

        // Sender pause until all is back, then a small timeout and wide step.
        drain();
        write_reg(CFG_JOY_TIMEOUT, 16'd2);
        write_reg(CFG_SLEW_STEP, 16'd4096);
        write_reg(CFG_STOP_THRESH, 16'd32767);
        for (int i = 0; i < 6; i++) begin
            t = make_tick(MODE_FAST, (i == 0), 4000, -4000, 2000, -3000, 100, 100);
            send_tick(t, 0, '0);
        end
        send_tick(make_tick(MODE_STOP, 0, 0, 0, 0, 0, 65535, 32767), 0, '0);
        drain();
        write_reg(CFG_SLEW_STEP, 16'd0);
        send_tick(make_tick(MODE_SLOW, 1, 100, 100, 100, 5, 0, 0), 0, '0);
        drain();
        write_reg(CFG_SLEW_STEP, 16'd8191);
        write_reg(CFG_LIM_SLOW, 16'd0);
        write_reg(CFG_LIM_FAST, 16'd32767);
        write_reg(CFG_LIM_OVERLAP, 16'd32767);
        write_reg(CFG_YAW_LIMIT, 16'd0);
        send_tick(make_tick(MODE_OVERLAP, 1, -32768, -32768, -32768, 9, 0, 0), 0, '0);
        send_tick(make_tick(MODE_FAST, 1, 32767, 32767, 32767, -9, 0, 0), 0, '0);
        send_tick(make_tick(MODE_SLOW, 1, 32767, 32767, 32767, -9, 0, 0), 0, '0);

        // Random phases, each with a fresh register setting.
        for (int ph = 0; ph < 13; ph++) begin
            drain();
            case (ph % 4)
                0: begin
                    write_reg(CFG_SLEW_STEP, 16'd4);
                    write_reg(CFG_STOP_THRESH, 16'd410);
                    write_reg(CFG_LIM_SLOW, 16'd2867);
                    write_reg(CFG_LIM_FAST, 16'd4915);
                    write_reg(CFG_LIM_OVERLAP, 16'd4096);
                    write_reg(CFG_YAW_LIMIT, 16'd2867);
                    write_reg(CFG_JOY_TIMEOUT, 16'd1000);
                end
                1: begin
                    write_reg(CFG_SLEW_STEP, 16'($urandom_range(1, 4096)));
                    write_reg(CFG_STOP_THRESH, 16'($urandom_range(0, 32767)));
                    write_reg(CFG_JOY_TIMEOUT, 16'($urandom_range(0, 8)));
                end
                2: begin
                    write_reg(CFG_SLEW_STEP, 16'($urandom_range(200, 1500)));
                    write_reg(CFG_LIM_SLOW, 16'($urandom_range(0, 32767)));
                    write_reg(CFG_LIM_FAST, 16'($urandom_range(0, 32767)));
                    write_reg(CFG_LIM_OVERLAP, 16'($urandom_range(0, 32767)));
                    write_reg(CFG_YAW_LIMIT, 16'($urandom_range(0, 32767)));
                    write_reg(CFG_STOP_THRESH, 16'($urandom_range(0, 2000)));
                end
                default: begin
                    write_reg(CFG_SLEW_STEP, 16'($urandom_range(1, 8191)));
                    write_reg(CFG_JOY_TIMEOUT, 16'hFFFF);
                    write_reg(CFG_STOP_THRESH, 16'd0);
                end
            endcase
            for (int i = 0; i < 100; i++) send_tick(rand_tick(), 0, '0);
        end
        drain();
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
design/vcsl_pkg.sv
design/vcsl_in_if.sv
design/vcsl_out_if.sv
design/vcsl_ctrl.sv
design/vcsl_dp.sv
design/velocity_command_slew_limiter.sv
design/vcsl_checker.sv
test/velocity_command_slew_limiter_tb.sv
